// File: hw/rtl/rge_pkg.sv
// Shared types and constants for the RGB gradient energy stencil.
// No dependencies; imported by the top, rge_front, rge_back, rge_checker and the testbench.
package rge_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam int IMAGE_WIDTH_RESET  = 640;
    localparam int IMAGE_HEIGHT_RESET = 480;

    localparam int CHAN_W     = 8;
    localparam int SQ_W       = 2 * CHAN_W;
    localparam int COORD_W    = 11;
    localparam int ENERGY_W   = 19;
    localparam int ENERGY_MAX = 390150;

    localparam int CMD_DEPTH = 2;
    localparam int OUT_DEPTH = 8;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rge_pixel_t;

    localparam int PIX_W = $bits(rge_pixel_t);

    typedef struct packed {
        logic              frame_start;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rge_in_t;

    typedef struct packed {
        logic [COORD_W-1:0]  center_x;
        logic [COORD_W-1:0]  center_y;
        logic [ENERGY_W-1:0] edge_energy;
        logic                frame_last;
    } rge_out_t;

    typedef struct packed {
        logic               emit;
        logic               last;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        rge_pixel_t         pixel;
    } rge_cmd_t;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

// File: hw/rtl/rgb_gradient_energy_stencil.sv
// Top level of the RGB gradient energy stencil.
// Depends on rge_pkg, rge_front, rge_fifo and rge_back.
//
// Pixels enter in raster order on the s_ channel (valid/ready); frame_start
// restarts the column and row counters. Frame size is set through the cfg_
// channel (index 0 width, index 1 height). The user must write it only
// while idle; the block does not enforce this. Zero is taken as one and
// values above the maximum as the maximum. For each interior pixel one item
// leaves on the m_ channel with its coordinates, the summed squared RGB
// central differences and a flag on the last interior pixel. Border pixels
// give no item. The item for (x, y-1) is produced by the pixel at (x, y).
// Throughput: one pixel per clock while the result buffer has room, set by
// the two line buffers each doing two reads and one write per cycle.
// Path: after the pixel that completes its stencil is accepted, its item
// passes through the command queue, buffer read, difference and square, and
// sum into the result buffer before it appears on m_.
// Stall: an 8-item result buffer absorbs back-pressure; once it and the
// pipeline are full the 2-entry command queue fills and s_ready drops.
// Reset: counters clear, size returns to 640 x 480, all queues empty. The
// line buffers are not cleared; s_ready is high in the first cycle after.
module rgb_gradient_energy_stencil import rge_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  rge_in_t                s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output rge_out_t               m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int QW = XW + $bits(rge_cmd_t);

    logic          fe_valid, fe_ready;
    rge_cmd_t      fe_cmd;
    logic [XW-1:0] fe_addr;
    logic          be_valid, be_ready;
    rge_cmd_t      be_cmd;
    logic [XW-1:0] be_addr;

    rge_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (fe_valid),
        .cmd_ready (fe_ready),
        .cmd       (fe_cmd),
        .cmd_addr  (fe_addr)
    );

    rge_fifo #(
        .WIDTH (QW),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_data   ({fe_addr, fe_cmd}),
        .out_valid (be_valid),
        .out_ready (be_ready),
        .out_data  ({be_addr, be_cmd}),
        .count     ()
    );

    rge_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (be_valid),
        .cmd_ready (be_ready),
        .cmd       (be_cmd),
        .cmd_addr  (be_addr),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: hw/rtl/rge_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
// No dependencies.
module rge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    output logic [WIDTH-1:0]                     rdata_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                     rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rd_a_reg <= mem_reg[raddr_a];
        rd_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

// File: hw/rtl/rge_fifo.sv
// Small register FIFO with valid/ready on both sides and a fill count.
// No dependencies; used for the command queue and the result buffer.
module rge_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [WIDTH-1:0]             in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [WIDTH-1:0]             out_data,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// File: hw/rtl/rge_front.sv
// Front end: frame size registers, raster counters and pixel classification.
// Depends on rge_pkg; emits one command per accepted pixel.
module rge_front import rge_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  rge_in_t                      s_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output logic                         cmd_valid,
    input  logic                         cmd_ready,
    output rge_cmd_t                     cmd,
    output logic [$clog2(MAX_WIDTH)-1:0] cmd_addr
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int WVW = $clog2(MAX_WIDTH + 1);
    localparam int WVH = $clog2(MAX_HEIGHT + 1);
    localparam int CWW = (WVW > CFG_DATA_W) ? WVW : CFG_DATA_W;
    localparam int CWH = (WVH > CFG_DATA_W) ? WVH : CFG_DATA_W;
    localparam int XE  = (XW > COORD_W) ? XW : COORD_W;
    localparam int YE  = (YW > COORD_W) ? YW : COORD_W;
    localparam int WIDTH_RST  = (IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                : IMAGE_WIDTH_RESET;
    localparam int HEIGHT_RST = (IMAGE_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                                  : IMAGE_HEIGHT_RESET;

    logic [WVW-1:0] width_reg, width_next;
    logic [WVH-1:0] height_reg, height_next;
    logic [XW-1:0]  col_reg, col_next;
    logic [YW-1:0]  row_reg, row_next;
    logic [XW-1:0]  col_s, x;
    logic [YW-1:0]  row_s, y;
    logic [WVW-1:0] x_inc;
    logic [WVH-1:0] y_inc;
    logic           accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = cmd_ready;
    assign cmd_valid = s_valid;
    assign accept    = s_valid && cmd_ready;

    // clamp size on write
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    if (cfg_data == '0) begin
                        width_next = WVW'(1);
                    end else if (CWW'(cfg_data) > CWW'(MAX_WIDTH)) begin
                        width_next = WVW'(MAX_WIDTH);
                    end else begin
                        width_next = WVW'(cfg_data);
                    end
                end
                REG_IMAGE_HEIGHT: begin
                    if (cfg_data == '0) begin
                        height_next = WVH'(1);
                    end else if (CWH'(cfg_data) > CWH'(MAX_HEIGHT)) begin
                        height_next = WVH'(MAX_HEIGHT);
                    end else begin
                        height_next = WVH'(cfg_data);
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        col_s = s_data.frame_start ? '0 : col_reg;
        row_s = s_data.frame_start ? '0 : row_reg;
        x     = (WVW'(col_s) >= width_reg)  ? '0 : col_s;
        y     = (WVH'(row_s) >= height_reg) ? '0 : row_s;
        x_inc = WVW'(x) + WVW'(1);
        y_inc = WVH'(y) + WVH'(1);

        cmd.emit     = (y >= YW'(2)) && (x != '0) && (x_inc < width_reg);
        cmd.last     = (x_inc == width_reg - WVW'(1)) && (y_inc == height_reg);
        cmd.center_x = COORD_W'(XE'(x));
        cmd.center_y = COORD_W'(YE'(y) - YE'(1));
        cmd.pixel    = '{red: s_data.red, green: s_data.green, blue: s_data.blue};
        cmd_addr     = x;

        if (x_inc >= width_reg) begin
            col_next = '0;
            row_next = (y_inc >= height_reg) ? '0 : YW'(y_inc);
        end else begin
            col_next = XW'(x_inc);
            row_next = y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WVW'(WIDTH_RST);
            height_reg <= WVH'(HEIGHT_RST);
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

endmodule

// File: hw/rtl/rge_back.sv
// Back end: line buffers with write bypass, squared differences, energy sum
// and result buffer. Depends on rge_pkg, rge_ram and rge_fifo.
module rge_back import rge_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  rge_cmd_t                     cmd,
    input  logic [$clog2(MAX_WIDTH)-1:0] cmd_addr,
    output logic                         m_valid,
    input  logic                         m_ready,
    output rge_out_t                     m_data
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int OCW = $clog2(OUT_DEPTH + 1);

    logic                pop;
    logic [OCW-1:0]      out_count;
    logic [1:0]          inflight;
    logic [XW-1:0]       addr_right, addr_left;

    logic [PIX_W-1:0]    ra_right_rd, ra_centre_rd, rt_left_rd, rt_up_rd;
    rge_pixel_t          ra_right, ra_centre, rt_left, rt_up;

    logic                b1_valid_reg;
    rge_cmd_t            b1_cmd_reg;
    logic [XW-1:0]       b1_addr_reg;

    logic                wb_valid_reg;
    logic [XW-1:0]       wb_addr_reg;
    rge_pixel_t          wb_above_reg;
    rge_pixel_t          wb_two_reg;

    logic                b2_emit_reg;
    rge_cmd_t            b2_cmd_reg;
    rge_pixel_t          b2_left_reg, b2_right_reg, b2_up_reg, b2_down_reg;
    logic [SQ_W-1:0]     sq [6];

    logic                b3_emit_reg;
    rge_cmd_t            b3_cmd_reg;
    logic [SQ_W-1:0]     b3_sq_reg [6];
    rge_out_t            result;

    assign inflight = {1'b0, b1_valid_reg && b1_cmd_reg.emit}
                    + {1'b0, b2_emit_reg} + {1'b0, b3_emit_reg};
    assign cmd_ready = ((OCW + 1)'(out_count) + (OCW + 1)'(inflight))
                       < (OCW + 1)'(OUT_DEPTH);
    assign pop        = cmd_valid && cmd_ready;
    assign addr_right = cmd_addr + XW'(1);
    assign addr_left  = cmd_addr - XW'(1);

    rge_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_above (
        .aclk    (aclk),
        .we      (b1_valid_reg),
        .waddr   (b1_addr_reg),
        .wdata   (b1_cmd_reg.pixel),
        .raddr_a (addr_right),
        .rdata_a (ra_right_rd),
        .raddr_b (cmd_addr),
        .rdata_b (ra_centre_rd)
    );

    rge_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_two_above (
        .aclk    (aclk),
        .we      (b1_valid_reg),
        .waddr   (b1_addr_reg),
        .wdata   (ra_centre),
        .raddr_a (addr_left),
        .rdata_a (rt_left_rd),
        .raddr_b (cmd_addr),
        .rdata_b (rt_up_rd)
    );

    // forward the previous cycle's write over a stale read
    always_comb begin
        ra_right  = ra_right_rd;
        ra_centre = ra_centre_rd;
        rt_left   = rt_left_rd;
        rt_up     = rt_up_rd;
        if (wb_valid_reg) begin
            if (wb_addr_reg == b1_addr_reg + XW'(1)) begin
                ra_right = wb_above_reg;
            end
            if (wb_addr_reg == b1_addr_reg) begin
                ra_centre = wb_above_reg;
                rt_up     = wb_two_reg;
            end
            if (wb_addr_reg == b1_addr_reg - XW'(1)) begin
                rt_left = wb_two_reg;
            end
        end
    end

    always_comb begin
        sq[0] = sq_diff(b2_left_reg.red,   b2_right_reg.red);
        sq[1] = sq_diff(b2_left_reg.green, b2_right_reg.green);
        sq[2] = sq_diff(b2_left_reg.blue,  b2_right_reg.blue);
        sq[3] = sq_diff(b2_up_reg.red,     b2_down_reg.red);
        sq[4] = sq_diff(b2_up_reg.green,   b2_down_reg.green);
        sq[5] = sq_diff(b2_up_reg.blue,    b2_down_reg.blue);
    end

    always_comb begin
        result.center_x    = b3_cmd_reg.center_x;
        result.center_y    = b3_cmd_reg.center_y;
        result.edge_energy = ENERGY_W'(b3_sq_reg[0]) + ENERGY_W'(b3_sq_reg[1])
                           + ENERGY_W'(b3_sq_reg[2]) + ENERGY_W'(b3_sq_reg[3])
                           + ENERGY_W'(b3_sq_reg[4]) + ENERGY_W'(b3_sq_reg[5]);
        result.frame_last  = b3_cmd_reg.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
            b2_emit_reg  <= 1'b0;
            b3_emit_reg  <= 1'b0;
        end else begin
            b1_valid_reg <= pop;
            wb_valid_reg <= b1_valid_reg;
            b2_emit_reg  <= b1_valid_reg && b1_cmd_reg.emit;
            b3_emit_reg  <= b2_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            b1_cmd_reg  <= cmd;
            b1_addr_reg <= cmd_addr;
        end
        wb_addr_reg  <= b1_addr_reg;
        wb_above_reg <= b1_cmd_reg.pixel;
        wb_two_reg   <= ra_centre;
        b2_cmd_reg   <= b1_cmd_reg;
        b2_left_reg  <= rt_left;
        b2_right_reg <= ra_right;
        b2_up_reg    <= rt_up;
        b2_down_reg  <= b1_cmd_reg.pixel;
        b3_cmd_reg   <= b2_cmd_reg;
        b3_sq_reg    <= sq;
    end

    rge_fifo #(
        .WIDTH ($bits(rge_out_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (b3_emit_reg),
        .in_ready  (),
        .in_data   (result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data),
        .count     (out_count)
    );

endmodule

// File: hw/rtl/rge_checker.sv
// Port-level checks for the RGB gradient energy stencil, bound to the top.
// Depends on rge_pkg.
module rge_checker import rge_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input rge_out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    a_energy_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.edge_energy <= ENERGY_W'(ENERGY_MAX))
        else $error("edge energy above the largest possible value");

    a_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.center_x != '0 && m_data.center_y != '0)
        else $error("result item on a border pixel");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("queues not empty after reset");

endmodule

bind rgb_gradient_energy_stencil rge_checker u_rge_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for the RGB gradient energy stencil.
// Depends on rge_pkg and rgb_gradient_energy_stencil; predicts each energy item
// from a line-buffer model kept in step with every accepted pixel and write.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rge_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_ITEMS  = 280;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    rge_in_t                s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    rge_out_t               m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic [CFG_DATA_W-1:0] width_reg  = CFG_DATA_W'(IMAGE_WIDTH_RESET);
    logic [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(IMAGE_HEIGHT_RESET);
    rge_pixel_t            line_above     [MAX_WIDTH_DEF];
    rge_pixel_t            line_two_above [MAX_WIDTH_DEF];
    int unsigned           col_pos = 0;
    int unsigned           row_pos = 0;
    rge_out_t              pending_energy [$];
    rge_in_t               pixel_plan [$];

    int       fail_count      = 0;
    int       cycle_count     = 0;
    int       hold_off_cycles = 0;
    bit       steady_sender   = 1'b0;
    int       burst_left      = 0;
    rx_mode_e rx_mode         = RX_OPEN;
    int       rx_mode_left    = 0;
    int       rx_phase        = 0;

    rgb_gradient_energy_stencil dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v, int unsigned limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    function automatic int unsigned chan_sq(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
        int unsigned d;
        d = (a > b) ? a - b : b - a;
        return d * d;
    endfunction

    function automatic int unsigned colour_dist(rge_pixel_t a, rge_pixel_t b);
        return chan_sq(a.red, b.red) + chan_sq(a.green, b.green) + chan_sq(a.blue, b.blue);
    endfunction

    function automatic rge_in_t make_px(bit fs, logic [PIX_W-1:0] rgb);
        rge_in_t p;
        p.frame_start = fs;
        {p.red, p.green, p.blue} = rgb;
        return p;
    endfunction

    function automatic void queue_pixel(rge_in_t p);
        pixel_plan.insert(pixel_plan.size(), p);
    endfunction

    function automatic void queue_result(rge_out_t r);
        pending_energy.insert(pending_energy.size(), r);
    endfunction

    function automatic void plan_pixels(int n, bit restart);
        for (int i = 0; i < n; i++)
            queue_pixel(make_px(restart && i == 0, PIX_W'($urandom())));
    endfunction

    task automatic predict_energy(rge_in_t px);
        int unsigned w, h, x, y;
        rge_pixel_t  cur;
        rge_out_t    res;
        w   = clamp_dim(width_reg, MAX_WIDTH_DEF);
        h   = clamp_dim(height_reg, MAX_HEIGHT_DEF);
        cur = {px.red, px.green, px.blue};
        if (px.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        x = col_pos;
        y = row_pos;
        if (y >= 2 && x >= 1 && x + 2 <= w) begin
            res.center_x    = COORD_W'(x);
            res.center_y    = COORD_W'(y - 1);
            res.edge_energy = ENERGY_W'(colour_dist(line_two_above[x-1], line_above[x+1]) +
                                        colour_dist(line_two_above[x], cur));
            res.frame_last  = (x + 2 == w) && (y + 1 == h);
            queue_result(res);
        end
        line_two_above[x] = line_above[x];
        line_above[x]     = cur;
        col_pos = x + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = y + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    task automatic send_pixel(rge_in_t px, bit more);
        int gap;
        gap = 0;
        s_valid <= 1'b1;
        s_data  <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_energy(px);
        if (!steady_sender) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap        = $urandom_range(1, 6);
            end else begin
                burst_left--;
            end
        end
        if (!more || gap > 0) begin
            s_valid <= 1'b0;
            repeat ((gap > 0) ? gap : 1) @(posedge aclk);
        end
    endtask

    task automatic play_plan();
        while (pixel_plan.size() != 0) begin
            rge_in_t px;
            px = pixel_plan.pop_front();
            send_pixel(px, pixel_plan.size() != 0);
        end
    endtask

    task automatic wait_idle();
        while (pending_energy.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_IMAGE_WIDTH:  width_reg  = val;
            REG_IMAGE_HEIGHT: height_reg = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    endtask

    task automatic run_sized(int unsigned w, int unsigned h, int n);
        set_size(w, h);
        plan_pixels(n, 1'b1);
        play_plan();
    endtask

    task automatic test_reset_size();
        plan_pixels(48, 1'b1);
        play_plan();
    endtask

    task automatic test_colour_extremes();
        set_size(3, 3);
        pixel_plan = '{make_px(1'b1, 24'h123456), make_px(1'b0, 24'h000000),
                       make_px(1'b0, 24'h654321), make_px(1'b0, 24'h000000),
                       make_px(1'b0, 24'hABCDEF), make_px(1'b0, 24'hFFFFFF),
                       make_px(1'b0, 24'h0F0F0F), make_px(1'b0, 24'hFFFFFF),
                       make_px(1'b0, 24'hF0F0F0),
                       make_px(1'b0, 24'hEDCBA9), make_px(1'b0, 24'hFFFFFF),
                       make_px(1'b0, 24'h9ABCDE), make_px(1'b0, 24'hFFFFFF),
                       make_px(1'b0, 24'h543210), make_px(1'b0, 24'h000000),
                       make_px(1'b0, 24'hF0F0F0), make_px(1'b0, 24'h000000),
                       make_px(1'b0, 24'h0F0F0F)};
        for (int i = 0; i < 9; i++)
            queue_pixel(make_px(i == 0, 24'h5AA53C));
        play_plan();
    endtask

    task automatic test_degenerate_sizes();
        run_sized(0, 5, 15);
        run_sized(1, 4, 15);
        run_sized(2, 6, 15);
        run_sized(5, 2, 15);
        run_sized(6, 1, 15);
        run_sized(0, 0, 6);
        set_size(4, 3);
        write_reg(REG_SPARE, 12'hFFF);
        plan_pixels(24, 1'b1);
        play_plan();
    endtask

    task automatic test_largest_sizes();
        run_sized(12'hFFF, 3, 32);
        run_sized(3, MAX_HEIGHT_DEF, 48);
    endtask

    task automatic test_shrink_mid_frame();
        run_sized(8, 6, 21);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 12'd4);
        plan_pixels(14, 1'b0);
        play_plan();
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 12'd3);
        plan_pixels(20, 1'b0);
        play_plan();
    endtask

    task automatic test_output_backpressure();
        set_size(4, 40);
        steady_sender   = 1'b1;
        hold_off_cycles = 100;
        plan_pixels(120, 1'b1);
        play_plan();
        steady_sender = 1'b0;
        wait_idle();
        plan_pixels(40, 1'b0);
        play_plan();
    endtask

    task automatic test_random_frames();
        int          sent;
        int unsigned w, h, frame_len, n;
        bit          fs;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 2);
                1:       w = $urandom_range(13, 48);
                default: w = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 9))
                0:       h = $urandom_range(0, 2);
                1:       h = $urandom_range(11, 24);
                default: h = $urandom_range(3, 8);
            endcase
            steady_sender = ($urandom_range(0, 3) == 0);
            set_size(w, h);
            frame_len = clamp_dim(w, MAX_WIDTH_DEF) * clamp_dim(h, MAX_HEIGHT_DEF);
            n = frame_len * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
            if (n > 200) n = 200;
            if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
            for (int i = 0; i < n; i++) begin
                fs = (i == 0) || (i % frame_len == 0 && $urandom_range(0, 1) == 1) ||
                     ($urandom_range(0, 39) == 0);
                queue_pixel(make_px(fs, PIX_W'($urandom())));
            end
            play_plan();
            sent += n;
        end
        steady_sender = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            m_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = rx_mode_e'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 200);
            end else begin
                rx_mode_left--;
            end
            rx_phase = (rx_phase + 1) % 5;
            case (rx_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= (rx_phase < 2);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_energy.size() == 0) begin
                $error("unexpected item at x=%0d y=%0d", m_data.center_x, m_data.center_y);
                fail_count++;
            end else begin
                rge_out_t want;
                want = pending_energy.pop_front();
                if (m_data.center_x !== want.center_x) begin
                    $error("center_x: expected %0d, got %0d", want.center_x, m_data.center_x);
                    fail_count++;
                end
                if (m_data.center_y !== want.center_y) begin
                    $error("center_y: expected %0d, got %0d", want.center_y, m_data.center_y);
                    fail_count++;
                end
                if (m_data.edge_energy !== want.edge_energy) begin
                    $error("edge_energy: expected %0d, got %0d",
                           want.edge_energy, m_data.edge_energy);
                    fail_count++;
                end
                if (m_data.frame_last !== want.frame_last) begin
                    $error("frame_last: expected %0d, got %0d",
                           want.frame_last, m_data.frame_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_size();
        test_colour_extremes();
        test_degenerate_sizes();
        test_largest_sizes();
        test_shrink_mid_frame();
        test_output_backpressure();
        test_random_frames();
        for (int n = 0; n < 20000 && pending_energy.size() != 0; n++) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_energy.size() != 0) begin
            $error("%0d energy items never arrived", pending_energy.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/rge_pkg.sv
hw/rtl/rge_ram.sv
hw/rtl/rge_fifo.sv
hw/rtl/rge_front.sv
hw/rtl/rge_back.sv
hw/rtl/rgb_gradient_energy_stencil.sv
hw/rtl/rge_checker.sv
tb/testbench.sv
